// File: rtl/core/queue_and_stack_command_engine_assert.svh
// Assertion macros shared by the command engine.
`ifndef QUEUE_AND_STACK_COMMAND_ENGINE_ASSERT_SVH
`define QUEUE_AND_STACK_COMMAND_ENGINE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QSCE_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("command engine check failed");

// The consequent must hold in the cycle after the antecedent.
`define QSCE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("command engine check failed");

// The condition must never hold.
`define QSCE_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("command engine check failed");

`endif

// File: rtl/core/qsce_pkg.sv
`default_nettype none
package qsce_pkg;

  localparam int DEPTH_DEF = 32;
  localparam int DATA_W    = 32;
  localparam int REQ_W     = 3;
  localparam int STAT_W    = 2;

  localparam logic TGT_QUEUE = 1'b0;
  localparam logic TGT_STACK = 1'b1;

  localparam logic [REQ_W-1:0] REQ_PUSH  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_POP   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_PEEK  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_PRINT = 3'd3;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 3'd4;

  localparam logic [STAT_W-1:0] STAT_VALUE = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

endpackage
`default_nettype wire

// File: rtl/core/qsce_cmd_if.sv
`default_nettype none
interface qsce_cmd_if;
  import qsce_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     target;
  logic [REQ_W-1:0]         req_type;
  logic signed [DATA_W-1:0] push_value;

  modport source (output valid, output target, output req_type, output push_value,
                  input ready);
  modport sink   (input valid, input target, input req_type, input push_value,
                  output ready);
endinterface
`default_nettype wire

// File: rtl/core/qsce_res_if.sv
`default_nettype none
interface qsce_res_if;
  import qsce_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     which;
  logic [STAT_W-1:0]        status;
  logic signed [DATA_W-1:0] item_value;
  logic                     last;

  modport source (output valid, output which, output status, output item_value,
                  output last, input ready);
  modport sink   (input valid, input which, input status, input item_value,
                  input last, output ready);
endinterface
`default_nettype wire

// File: rtl/core/queue_and_stack_command_engine.sv
// Queue and stack command engine.
// One FIFO queue and one LIFO stack of signed 32-bit entries, DEPTH each.
// Commands arrive on in_cmd (target, req_type, push_value); results leave
// on out_res (which, status, item_value, last), last marking the final
// result word of a command. Both channels move a word when valid and ready
// are high at a rising clock edge.
// A successful push or a clear of a non-empty structure gives no result.
// Pop and peek first read the memory, then load the output register.
// Empty and full notices also pass through the output register.
// Print gives one entry a cycle while the receiver takes them, since the
// next entry is read from the entry memory as the current one is loaded.
// The output register frees the engine as soon as a result is loaded; when
// the receiver stalls, the next result waits in the sequencer and in_cmd
// stays low on ready until it is loaded.
// Synchronous reset empties both structures; the memories are not cleared.
`default_nettype none
`include "queue_and_stack_command_engine_assert.svh"
module queue_and_stack_command_engine #(
  parameter int DEPTH = qsce_pkg::DEPTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  qsce_cmd_if.sink   in_cmd,
  qsce_res_if.source out_res
);
  import qsce_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic              q_we;
  logic [AW-1:0]     q_waddr;
  logic [DATA_W-1:0] q_wdata;
  logic              s_we;
  logic [AW-1:0]     s_waddr;
  logic [DATA_W-1:0] s_wdata;
  logic              rd_en;
  logic [AW-1:0]     q_raddr;
  logic [AW-1:0]     s_raddr;
  logic [DATA_W-1:0] q_rdata;
  logic [DATA_W-1:0] s_rdata;

  qsce_seq #(.DEPTH(DEPTH)) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (in_cmd),
    .res     (out_res),
    .q_we    (q_we),
    .q_waddr (q_waddr),
    .q_wdata (q_wdata),
    .s_we    (s_we),
    .s_waddr (s_waddr),
    .s_wdata (s_wdata),
    .rd_en   (rd_en),
    .q_raddr (q_raddr),
    .s_raddr (s_raddr),
    .q_rdata (q_rdata),
    .s_rdata (s_rdata)
  );

  qsce_mem #(.DEPTH(DEPTH), .WIDTH(DATA_W)) u_queue_mem (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .re    (rd_en),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  qsce_mem #(.DEPTH(DEPTH), .WIDTH(DATA_W)) u_stack_mem (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .re    (rd_en),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  // A command touches one structure, so both memories never take a word.
  `QSCE_ASSERT_NEVER(a_one_writer, clk, rst_n, q_we && s_we)
  // Entries are written only by an accepted push.
  `QSCE_ASSERT_SAME(a_write_on_push, clk, rst_n, q_we || s_we,
    in_cmd.valid && in_cmd.ready && (in_cmd.req_type == REQ_PUSH))
  // A command that always answers holds off the next one while it runs.
  `QSCE_ASSERT_NEXT(a_busy_after_read, clk, rst_n,
    in_cmd.valid && in_cmd.ready &&
    (in_cmd.req_type == REQ_POP || in_cmd.req_type == REQ_PEEK ||
     in_cmd.req_type == REQ_PRINT), !in_cmd.ready)

endmodule
`default_nettype wire

// File: rtl/core/qsce_mem.sv
`default_nettype none
module qsce_mem #(
  parameter int DEPTH = qsce_pkg::DEPTH_DEF,
  parameter int WIDTH = qsce_pkg::DATA_W,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Read data holds until the next read, so a stalled result keeps its word.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// File: rtl/core/qsce_seq.sv
`default_nettype none
module qsce_seq #(
  parameter int DEPTH = qsce_pkg::DEPTH_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  qsce_cmd_if.sink                           cmd,
  qsce_res_if.source                         res,
  output logic                               q_we,
  output logic [AW-1:0]                      q_waddr,
  output logic [qsce_pkg::DATA_W-1:0]        q_wdata,
  output logic                               s_we,
  output logic [AW-1:0]                      s_waddr,
  output logic [qsce_pkg::DATA_W-1:0]        s_wdata,
  output logic                               rd_en,
  output logic [AW-1:0]                      q_raddr,
  output logic [AW-1:0]                      s_raddr,
  input  wire logic [qsce_pkg::DATA_W-1:0]   q_rdata,
  input  wire logic [qsce_pkg::DATA_W-1:0]   s_rdata
);
  import qsce_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW:0]   DEPTH_S = (AW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } seq_state_t;

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
                                             input logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= DEPTH_S) begin
      s = s - DEPTH_S;
    end
    return s[AW-1:0];
  endfunction

  seq_state_t          state_r, state_nxt;
  logic [AW-1:0]       q_head_r, q_head_nxt;
  logic [CW-1:0]       q_cnt_r, q_cnt_nxt;
  logic [CW-1:0]       s_cnt_r, s_cnt_nxt;
  logic                r_which_r, r_which_nxt;
  logic [STAT_W-1:0]   r_status_r, r_status_nxt;
  logic                r_print_r, r_print_nxt;
  logic [AW-1:0]       idx_r, idx_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic                out_which_r, out_which_nxt;
  logic [STAT_W-1:0]   out_status_r, out_status_nxt;
  logic [DATA_W-1:0]   out_value_r, out_value_nxt;
  logic                out_last_r, out_last_nxt;

  logic                acc;
  logic [CW-1:0]       sel_cnt;
  logic                sel_empty;
  logic                sel_full;
  logic                push_ok;
  logic [CW-1:0]       run_cnt;
  logic                run_last;
  logic                out_free;
  logic                walk_adv;
  logic [AW-1:0]       off_nxt;
  logic [CW-1:0]       s_rd_cw;

  assign cmd.ready = (state_r == ST_IDLE);
  assign acc       = cmd.valid && cmd.ready;

  assign sel_cnt   = (cmd.target == TGT_STACK) ? s_cnt_r : q_cnt_r;
  assign sel_empty = (sel_cnt == '0);
  assign sel_full  = (sel_cnt == DEPTH_C);
  assign push_ok   = acc && (cmd.req_type == REQ_PUSH) && !sel_full;

  assign q_we    = push_ok && (cmd.target == TGT_QUEUE);
  assign q_waddr = wrap_add(q_head_r, q_cnt_r[AW-1:0]);
  assign q_wdata = cmd.push_value;
  assign s_we    = push_ok && (cmd.target == TGT_STACK);
  assign s_waddr = s_cnt_r[AW-1:0];
  assign s_wdata = cmd.push_value;

  // At acceptance the read targets the front or top entry; during a print
  // walk it targets the entry after the one being emitted.
  assign off_nxt = idx_r + AW'(1);
  assign q_raddr = (state_r == ST_IDLE) ? q_head_r : wrap_add(q_head_r, off_nxt);
  assign s_rd_cw = s_cnt_r - CW'(1) - ((state_r == ST_IDLE) ? '0 : CW'(off_nxt));
  assign s_raddr = s_rd_cw[AW-1:0];
  assign rd_en   = acc || walk_adv;

  assign run_cnt  = r_which_r ? s_cnt_r : q_cnt_r;
  assign run_last = !r_print_r || (CW'(idx_r) == (run_cnt - CW'(1)));
  assign out_free = !out_valid_r || res.ready;
  assign walk_adv = (state_r == ST_RUN) && out_free && !run_last;

  always_comb begin
    state_nxt      = state_r;
    q_head_nxt     = q_head_r;
    q_cnt_nxt      = q_cnt_r;
    s_cnt_nxt      = s_cnt_r;
    r_which_nxt    = r_which_r;
    r_status_nxt   = r_status_r;
    r_print_nxt    = r_print_r;
    idx_nxt        = idx_r;
    out_valid_nxt  = out_valid_r && !res.ready;
    out_which_nxt  = out_which_r;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_last_nxt   = out_last_r;

    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          r_which_nxt  = cmd.target;
          r_status_nxt = sel_empty ? STAT_EMPTY : STAT_VALUE;
          r_print_nxt  = 1'b0;
          idx_nxt      = '0;
          case (cmd.req_type)
            REQ_PUSH: begin
              if (sel_full) begin
                r_status_nxt = STAT_FULL;
                state_nxt    = ST_RUN;
              end else if (cmd.target == TGT_STACK) begin
                s_cnt_nxt = s_cnt_r + CW'(1);
              end else begin
                q_cnt_nxt = q_cnt_r + CW'(1);
              end
            end
            REQ_POP: begin
              state_nxt = ST_RUN;
              if (!sel_empty) begin
                if (cmd.target == TGT_STACK) begin
                  s_cnt_nxt = s_cnt_r - CW'(1);
                end else begin
                  q_cnt_nxt  = q_cnt_r - CW'(1);
                  q_head_nxt = wrap_add(q_head_r, AW'(1));
                end
              end
            end
            REQ_PEEK: begin
              state_nxt = ST_RUN;
            end
            REQ_PRINT: begin
              state_nxt   = ST_RUN;
              r_print_nxt = !sel_empty;
            end
            REQ_CLEAR: begin
              if (sel_empty) begin
                state_nxt = ST_RUN;
              end else if (cmd.target == TGT_STACK) begin
                s_cnt_nxt = '0;
              end else begin
                q_cnt_nxt  = '0;
                q_head_nxt = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_RUN: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_which_nxt  = r_which_r;
          out_status_nxt = r_status_r;
          out_value_nxt  = (r_status_r == STAT_VALUE) ?
                           (r_which_r ? s_rdata : q_rdata) : '0;
          out_last_nxt   = run_last;
          if (run_last) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = off_nxt;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      q_head_r    <= '0;
      q_cnt_r     <= '0;
      s_cnt_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      q_head_r    <= q_head_nxt;
      q_cnt_r     <= q_cnt_nxt;
      s_cnt_r     <= s_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    r_which_r    <= r_which_nxt;
    r_status_r   <= r_status_nxt;
    r_print_r    <= r_print_nxt;
    idx_r        <= idx_nxt;
    out_which_r  <= out_which_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign res.valid      = out_valid_r;
  assign res.which      = out_which_r;
  assign res.status     = out_status_r;
  assign res.item_value = out_value_r;
  assign res.last       = out_last_r;

endmodule
`default_nettype wire
